@@ rtl/slpg_pkg.sv @@
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types, codes and constant tables of the status LED pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

  // Field widths
  localparam int LevelW = 6;
  localparam int StateW = 3;
  localparam int ModeW  = 2;

  // Fixed levels
  localparam logic [LevelW-1:0] FullLevel   = 6'd45;
  localparam logic [LevelW-1:0] BreathStep  = 6'd3;
  localparam logic [LevelW-1:0] BreathFloor = 6'd4;
  localparam logic [LevelW-1:0] GreenLevel  = 6'd35;

  // Base colour components
  localparam int BaseHigh = 35;
  localparam int BaseMid  = 22;
  localparam int BaseLow  = 12;

  // Requested indicator state
  typedef enum logic [StateW-1:0] {
    ST_IDLE      = 3'd0,
    ST_SOLID     = 3'd1,
    ST_BREATHING = 3'd2,
    ST_SPEAKING  = 3'd3,
    ST_SUCCESS   = 3'd4,
    ST_CMD_FAIL  = 3'd5,
    ST_LINK_FAIL = 3'd6,
    ST_OTHER     = 3'd7
  } led_state_t;

  // Colour mode register codes
  typedef enum logic [ModeW-1:0] {
    MODE_ONLINE     = 2'd0,
    MODE_SERVERLESS = 2'd1,
    MODE_OFFLINE    = 2'd2,
    MODE_UNKNOWN    = 2'd3
  } color_mode_t;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } rgb_t;

  // One entry per breathing level: base * level / 45, truncated
  typedef logic [(1<<LevelW)-1:0][LevelW-1:0] scale_tbl_t;

  function automatic scale_tbl_t build_scale(input int base);
    scale_tbl_t tbl;
    int         prod;
    for (int i = 0; i < (1 << LevelW); i++) begin
      prod   = (base * i) / 45;
      tbl[i] = LevelW'(prod);
    end
    return tbl;
  endfunction

  localparam scale_tbl_t ScaleHigh = build_scale(BaseHigh);
  localparam scale_tbl_t ScaleMid  = build_scale(BaseMid);
  localparam scale_tbl_t ScaleLow  = build_scale(BaseLow);

  // Mode colour at a given level; level 45 gives the full base colour
  function automatic rgb_t mode_color(input color_mode_t mode,
                                      input logic [LevelW-1:0] level);
    rgb_t c;
    c = '0;
    unique case (mode)
      MODE_ONLINE: begin
        c.blue = ScaleHigh[level];
      end
      MODE_SERVERLESS: begin
        c.red  = ScaleMid[level];
        c.blue = ScaleHigh[level];
      end
      MODE_OFFLINE: begin
        c.red   = ScaleHigh[level];
        c.green = ScaleLow[level];
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

@@ rtl/status_led_pattern_generator_unit.sv @@
// ----------------------------------------------------------------------------
// status_led_pattern_generator_unit
// One animation tick in, one RGB colour and next-tick wait out.
//
// Each accepted tick carries the requested indicator state and yields exactly
// one result: red, green and blue levels (0..45) and short_wait, which asks
// for the next tick after 45 ms (breathing) rather than 250 ms. The colour is
// computed in the cycle of acceptance and held in an output register, so the
// result appears in the cycle after the tick and a new tick is taken every cycle
// while the output side keeps up; in_ready drops only while a result waits
// and out_ready is low. Breathing level, its direction and the blink phase
// survive other states. The colour mode is written through the cfg port,
// which is always ready, and should be changed only while no tick is pending.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [slpg_pkg::ModeW-1:0]  cfg_data,
  // tick input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [slpg_pkg::StateW-1:0] in_led_state,
  // colour output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [slpg_pkg::LevelW-1:0] out_red_level,
  output logic [slpg_pkg::LevelW-1:0] out_green_level,
  output logic [slpg_pkg::LevelW-1:0] out_blue_level,
  output logic                       out_short_wait
);

  import slpg_pkg::*;

  color_mode_t       mode_r;
  logic [LevelW-1:0] breath_level_r, breath_level_nxt;
  logic              breath_falling_r, breath_falling_nxt;
  logic              blink_lit_r, blink_lit_nxt;
  logic              out_valid_r;
  rgb_t              rgb_r, rgb_nxt;
  logic              short_wait_r, short_wait_nxt;
  logic              in_fire;
  logic [LevelW:0]   step_lv;
  led_state_t        st;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign st        = led_state_t'(in_led_state);

  // Latch the colour mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ONLINE;
    end else if (cfg_valid) begin
      mode_r <= color_mode_t'(cfg_data);
    end
  end

  // Step the breathing level by BreathStep; the next block bounces it at both ends
  always_comb begin
    if (breath_falling_r) begin
      step_lv = (breath_level_r >= BreathStep)
              ? {1'b0, breath_level_r - BreathStep} : '0;
    end else begin
      step_lv = {1'b0, breath_level_r} + {1'b0, BreathStep};
    end
  end

  // Compute the colour and the next animation state for this tick
  always_comb begin
    breath_level_nxt   = breath_level_r;
    breath_falling_nxt = breath_falling_r;
    blink_lit_nxt      = blink_lit_r;
    rgb_nxt            = '0;
    short_wait_nxt     = 1'b0;
    case (st)
      ST_SOLID: begin
        rgb_nxt = mode_color(mode_r, FullLevel);
      end
      ST_BREATHING: begin
        if (step_lv >= {1'b0, FullLevel}) begin
          breath_level_nxt   = FullLevel;
          breath_falling_nxt = 1'b1;
        end else if (step_lv <= {1'b0, BreathFloor}) begin
          breath_level_nxt   = BreathFloor;
          breath_falling_nxt = 1'b0;
        end else begin
          breath_level_nxt = step_lv[LevelW-1:0];
        end
        rgb_nxt        = mode_color(mode_r, breath_level_nxt);
        short_wait_nxt = 1'b1;
      end
      ST_SPEAKING, ST_SUCCESS: begin
        rgb_nxt.green = GreenLevel;
      end
      ST_CMD_FAIL: begin
        rgb_nxt.red = FullLevel;
      end
      ST_LINK_FAIL: begin
        blink_lit_nxt = !blink_lit_r;
        if (!blink_lit_r) begin
          rgb_nxt.red = FullLevel;
        end
      end
      default: begin
        rgb_nxt = '0;
      end
    endcase
  end

  // Advance animation state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      breath_level_r   <= '0;
      breath_falling_r <= 1'b0;
      blink_lit_r      <= 1'b0;
    end else if (in_fire) begin
      breath_level_r   <= breath_level_nxt;
      breath_falling_r <= breath_falling_nxt;
      blink_lit_r      <= blink_lit_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rgb_r        <= rgb_nxt;
      short_wait_r <= short_wait_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = rgb_r.red;
  assign out_green_level = rgb_r.green;
  assign out_blue_level  = rgb_r.blue;
  assign out_short_wait  = short_wait_r;

  // Breathing level stays at reset value or inside its bounce range
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (breath_level_r == '0) ||
    (breath_level_r >= BreathFloor && breath_level_r <= FullLevel))
    else $error("breathing level out of range");

  // A breathing tick yields a short-wait result next cycle
  a_breath_short: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (st == ST_BREATHING) |=> out_valid_r && out_short_wait)
    else $error("breathing result lacks short wait");

  // A link-failed tick flips the blink phase and lights red with it
  a_blink_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (st == ST_LINK_FAIL) |=>
      (blink_lit_r != $past(blink_lit_r)) &&
      ((out_red_level == FullLevel) == blink_lit_r))
    else $error("blink phase did not toggle");

  // Only breathing moves the breathing state
  a_breath_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && (st == ST_BREATHING)) |=>
      $stable(breath_level_r) && $stable(breath_falling_r))
    else $error("breathing state changed outside breathing");

  // No tick is refused while the output register is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the status LED pattern generator unit.
//
// Ticks are sent over the valid/ready input, the colour mode is changed
// through the cfg port between phases, and every result is checked against
// an in-bench model of the breathing, blink and colour logic. Phases vary
// sender gaps and receiver stalls, and one phase holds the output off for
// a long stretch so the unit fills and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slpg_pkg::*;

  localparam int ResetCycles = 8;
  localparam int LimitCycles = 400000;
  localparam int HoldLen     = 200;
  localparam int MaxReports  = 10;
  localparam int DrainCycles = 4;

  // Expected colour of one tick
  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic              short_wait;
  } tick_color_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ModeW-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  led_state_t        in_led_state = ST_IDLE;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [LevelW-1:0] out_red_level;
  logic [LevelW-1:0] out_green_level;
  logic [LevelW-1:0] out_blue_level;
  logic              out_short_wait;

  // Model state of the unit
  color_mode_t       model_mode = MODE_ONLINE;
  logic [LevelW-1:0] model_breath = '0;
  logic              model_falling = 1'b0;
  logic              model_blink = 1'b0;

  tick_color_t       pending_colors[$];
  int                mismatch_cnt = 0;
  int                cycle_cnt = 0;
  int                sender_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_reqs = 0;
  int                hold_seen = 0;
  int                hold_left = 0;

  status_led_pattern_generator_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_led_state    (in_led_state),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_short_wait  (out_short_wait)
  );

  always #5 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Base colour of a mode at full level
  function automatic rgb_t mode_base(input color_mode_t mode);
    rgb_t c;
    c = '0;
    case (mode)
      MODE_ONLINE: begin
        c.blue = LevelW'(BaseHigh);
      end
      MODE_SERVERLESS: begin
        c.red  = LevelW'(BaseMid);
        c.blue = LevelW'(BaseHigh);
      end
      MODE_OFFLINE: begin
        c.red   = LevelW'(BaseHigh);
        c.green = LevelW'(BaseLow);
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

  // Scale one channel by level/45, truncated
  function automatic logic [LevelW-1:0] scale_level(input logic [LevelW-1:0] base,
                                                    input logic [LevelW-1:0] level);
    int prod;
    prod = (int'(base) * int'(level)) / int'(FullLevel);
    return LevelW'(prod);
  endfunction

  // Advance the model by one tick and return its colour
  function automatic tick_color_t predict_tick(input led_state_t st);
    tick_color_t res;
    rgb_t        base;
    int          lv;
    res  = '0;
    base = mode_base(model_mode);
    case (st)
      ST_SOLID: begin
        res.red   = base.red;
        res.green = base.green;
        res.blue  = base.blue;
      end
      ST_BREATHING: begin
        lv = int'(model_breath);
        if (model_falling) begin
          lv = (lv >= int'(BreathStep)) ? lv - int'(BreathStep) : 0;
        end else begin
          lv = lv + int'(BreathStep);
        end
        if (lv >= int'(FullLevel)) begin
          lv = int'(FullLevel);
          model_falling = 1'b1;
        end else if (lv <= int'(BreathFloor)) begin
          lv = int'(BreathFloor);
          model_falling = 1'b0;
        end
        model_breath   = LevelW'(lv);
        res.red        = scale_level(base.red, model_breath);
        res.green      = scale_level(base.green, model_breath);
        res.blue       = scale_level(base.blue, model_breath);
        res.short_wait = 1'b1;
      end
      ST_SPEAKING, ST_SUCCESS: begin
        res.green = GreenLevel;
      end
      ST_CMD_FAIL: begin
        res.red = FullLevel;
      end
      ST_LINK_FAIL: begin
        model_blink = ~model_blink;
        if (model_blink) res.red = FullLevel;
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  // Track config writes, predict accepted ticks, check accepted results
  always @(posedge clk) begin
    tick_color_t exp_c;
    tick_color_t act_c;
    if (!rst_n) begin
      model_mode    = MODE_ONLINE;
      model_breath  = '0;
      model_falling = 1'b0;
      model_blink   = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        act_c = {out_red_level, out_green_level, out_blue_level, out_short_wait};
        if (pending_colors.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= MaxReports)
            $display("[%0d] unexpected result r=%0d g=%0d b=%0d sw=%0d", cycle_cnt,
                     act_c.red, act_c.green, act_c.blue, act_c.short_wait);
        end else begin
          exp_c = pending_colors.pop_front();
          if (act_c.red !== exp_c.red || act_c.green !== exp_c.green ||
              act_c.blue !== exp_c.blue || act_c.short_wait !== exp_c.short_wait) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= MaxReports)
              $display("[%0d] mismatch exp r=%0d g=%0d b=%0d sw=%0d got r=%0d g=%0d b=%0d sw=%0d",
                       cycle_cnt, exp_c.red, exp_c.green, exp_c.blue, exp_c.short_wait,
                       act_c.red, act_c.green, act_c.blue, act_c.short_wait);
          end
        end
      end
      if (in_valid && in_ready) pending_colors.push_back(predict_tick(in_led_state));
      if (cfg_valid && cfg_ready) model_mode = color_mode_t'(cfg_data);
    end
  end

  // Drive out_ready: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldLen;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one tick after a random gap and hold it until accepted
  task automatic send_tick(input led_state_t st);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_led_state <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write the colour mode while the unit is idle
  task automatic write_mode(input color_mode_t mode);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Favor breathing and blinking so the animation state gets deep coverage
  function automatic led_state_t random_led_state();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return ST_BREATHING;
    if (pick < 52) return ST_LINK_FAIL;
    return led_state_t'(StateW'($urandom_range(7)));
  endfunction

  // Every state once at the reset mode, blink twice, breathe up to the top
  task automatic test_directed();
    sender_idle_pct = 0;
    recv_stall_pct <= 0;
    for (int s = 0; s < 8; s++) send_tick(led_state_t'(StateW'(s)));
    send_tick(ST_LINK_FAIL);
    repeat (16) send_tick(ST_BREATHING);
    drain_results();
  endtask

  // Random ticks over each idling phase, with a new mode per phase
  task automatic test_random_phases();
    color_mode_t modes[4];
    int          idle_pcts[4];
    int          stall_pcts[4];
    modes      = '{MODE_UNKNOWN, MODE_SERVERLESS, MODE_OFFLINE, MODE_ONLINE};
    idle_pcts  = '{0, 78, 0, 28};
    stall_pcts = '{0, 0, 78, 28};
    for (int p = 0; p < 4; p++) begin
      write_mode(modes[p]);
      sender_idle_pct = idle_pcts[p];
      recv_stall_pct <= stall_pcts[p];
      for (int i = 0; i < 300; i++) begin
        if (i == 150) sender_idle_pct = 0;
        if (i == 200) sender_idle_pct = idle_pcts[p];
        send_tick(random_led_state());
      end
      drain_results();
    end
  endtask

  // Hold the output off while ticks keep coming so the input stalls
  task automatic test_backpressure();
    write_mode(MODE_SERVERLESS);
    sender_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_reqs      <= hold_reqs + 1;
    for (int i = 0; i < 120; i++) send_tick(random_led_state());
    drain_results();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0 && pending_colors.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
